// ===== src/dpf_pkg.sv =====
// Package with the widths and constants of the decimal palindrome filter.
`default_nettype none

package dpf_pkg;

   localparam int VALUE_W    = 32;
   localparam int MAX_DIGITS = 10;
   localparam int DIGIT_W    = 4;

   // Bits for a reversal of MAX_DIGITS decimal digits: ceil(MAX_DIGITS * log2(10)).
   localparam int REV_W = (MAX_DIGITS * 3322 + 999) / 1000;
   localparam int CMP_W = (REV_W > VALUE_W) ? REV_W : VALUE_W;

   // Exact quotient by ten for any 32-bit operand: (n * RECIP_TEN) >> RECIP_SHIFT.
   localparam int PROD_W           = 2 * VALUE_W;
   localparam logic [PROD_W-1:0] RECIP_TEN = 64'h0000_0000_CCCC_CCCD;
   localparam int RECIP_SHIFT      = 35;

   typedef logic [VALUE_W-1:0] word_type;
   typedef logic [REV_W-1:0]   rev_type;
   typedef logic [DIGIT_W-1:0] digit_type;

endpackage

`default_nettype wire

// ===== src/decimal_palindrome_filter_top.sv =====
// Streaming filter that passes only values whose decimal digits form a palindrome.
// Its pipeline is built from the input register, the magnitude stage,
// one stage per decimal digit, and the output register.
// Throughput is one request per cycle; the whole pipeline holds while a result is stalled.
// Synchronous reset clears all valid bits; requests are stalled while reset is high.
`default_nettype none

module decimal_palindrome_filter_top
   import dpf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_palindrome_value
);

   logic      adv;
   logic      pal;

   logic      in_vld_ff;
   word_type  in_value_ff;
   word_type  mag_in;

   logic      vld_ff   [MAX_DIGITS+1];
   word_type  value_ff [MAX_DIGITS+1];
   word_type  mag_ff   [MAX_DIGITS+1];
   word_type  rest_ff  [MAX_DIGITS+1];
   rev_type   rev_ff   [MAX_DIGITS+1];

   logic [PROD_W-1:0] prod_w  [MAX_DIGITS];
   word_type          quot_w  [MAX_DIGITS];
   digit_type         digit_w [MAX_DIGITS];
   word_type          rest_in [MAX_DIGITS];
   rev_type           rev_in  [MAX_DIGITS];

   logic      rsp_valid_ff;
   word_type  rsp_value_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = reset || !adv;

   assign mag_in = in_value_ff[VALUE_W-1] ? (~in_value_ff + word_type'(1)) : in_value_ff;

   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         prod_w[k]  = {{(PROD_W-VALUE_W){1'b0}}, rest_ff[k]} * RECIP_TEN;
         quot_w[k]  = word_type'(prod_w[k] >> RECIP_SHIFT);
         digit_w[k] = DIGIT_W'(rest_ff[k] - ((quot_w[k] << 3) + (quot_w[k] << 1)));
         rest_in[k] = quot_w[k];
         if (rest_ff[k] != '0) begin
            rev_in[k] = (rev_ff[k] << 3) + (rev_ff[k] << 1) + REV_W'(digit_w[k]);
         end else begin
            rev_in[k] = rev_ff[k];
         end
      end
   end

   assign pal = (rest_ff[MAX_DIGITS] == '0) &&
                (CMP_W'(rev_ff[MAX_DIGITS]) == CMP_W'(mag_ff[MAX_DIGITS]));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= MAX_DIGITS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         in_vld_ff    <= req_valid;
         vld_ff[0]    <= in_vld_ff;
         for (int k = 1; k <= MAX_DIGITS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[MAX_DIGITS] && pal;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_value_ff  <= word_type'(req_value);
         value_ff[0]  <= in_value_ff;
         mag_ff[0]    <= mag_in;
         rest_ff[0]   <= mag_in;
         rev_ff[0]    <= '0;
         for (int k = 1; k <= MAX_DIGITS; k++) begin
            value_ff[k] <= value_ff[k-1];
            mag_ff[k]   <= mag_ff[k-1];
            rest_ff[k]  <= rest_in[k-1];
            rev_ff[k]   <= rev_in[k-1];
         end
         rsp_value_ff <= value_ff[MAX_DIGITS];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_palindrome_value = signed'(rsp_value_ff);

   // An accepted request always occupies the input register in the next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_vld_ff)
      else $error("Accepted request did not enter the pipeline.");

   // A new result can only come from a valid item in the last digit stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[MAX_DIGITS]))
      else $error("Result appeared without a valid item in the last stage.");

   // The reciprocal division by ten in the first digit stage must always leave a decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      digit_w[0] <= digit_type'(9))
      else $error("Remainder by ten out of range.");

   // A held pipeline keeps its last stage unchanged.
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[MAX_DIGITS]) && $stable(value_ff[MAX_DIGITS]))
      else $error("Pipeline moved while the result was stalled.");

endmodule

`default_nettype wire

// ===== tb/sv/decimal_palindrome_filter_top_test.sv =====
// Self-checking testbench for the decimal palindrome filter: directed values, then random traffic.
`timescale 1ns / 1ps

module decimal_palindrome_filter_top_test;
   import dpf_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int PIPE_LATENCY  = MAX_DIGITS + 3;
   localparam int PHASE_ITEMS   = 667;
   localparam int LONG_HOLD     = 100;
   localparam int STALL_LIMIT   = 5000;
   localparam int N_DIRECTED    = 22;

   typedef struct packed {
      word_type value;
      logic     typed;
      logic     passes;
   } directed_case_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_value = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_palindrome_value;

   word_type pending_palindromes [$];
   word_type expected_value;
   int       error_count     = 0;
   int       send_idle_pct   = 0;
   int       recv_idle_pct   = 0;
   int       hold_ticket     = 0;
   int       hold_served     = 0;
   int       hold_left       = 0;
   int       quiet_cycles    = 0;

   directed_case_type directed_cases [N_DIRECTED] = '{
      '{32'd0,             1'b1, 1'b1},
      '{32'd1,             1'b1, 1'b1},
      '{-32'sd1,           1'b1, 1'b1},
      '{32'd9,             1'b1, 1'b1},
      '{32'd10,            1'b1, 1'b0},
      '{32'd11,            1'b1, 1'b1},
      '{32'd121,           1'b0, 1'b0},
      '{-32'sd121,         1'b0, 1'b0},
      '{32'd12321,         1'b0, 1'b0},
      '{32'd123,           1'b0, 1'b0},
      '{32'd100,           1'b0, 1'b0},
      '{-32'sd100,         1'b0, 1'b0},
      '{32'h7FFF_FFFF,     1'b1, 1'b0},
      '{32'h8000_0000,     1'b1, 1'b0},
      '{32'h8000_0001,     1'b1, 1'b0},
      '{32'd2147447412,    1'b1, 1'b1},
      '{-32'sd2147447412,  1'b1, 1'b1},
      '{32'd1000000001,    1'b0, 1'b0},
      '{32'd1000000009,    1'b1, 1'b0},
      '{32'd1234554321,    1'b0, 1'b0},
      '{32'h5555_5555,     1'b0, 1'b0},
      '{32'hAAAA_AAAA,     1'b0, 1'b0}
   };

   decimal_palindrome_filter_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_palindrome_value (rsp_palindrome_value)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic bit reads_same_reversed(input word_type bits);
      logic [63:0] magnitude;
      logic [63:0] rest;
      logic [63:0] mirrored;
      magnitude = bits[VALUE_W-1] ? {32'd0, ~bits + 32'd1} : {32'd0, bits};
      rest      = magnitude;
      mirrored  = '0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (rest != 0) begin
            mirrored = mirrored * 10 + rest % 10;
            rest     = rest / 10;
         end
      end
      return (rest == 0) && (mirrored == magnitude);
   endfunction

   function automatic word_type random_palindrome();
      logic [63:0] magnitude;
      int unsigned n_digits;
      int unsigned digits [10];
      word_type    w;
      magnitude = 64'hFFFF_FFFF;
      while (magnitude > 64'd2147483647) begin
         n_digits = $urandom_range(10, 1);
         for (int k = 0; k < (n_digits + 1) / 2; k++) begin
            digits[k]              = $urandom_range(9, (k == 0) ? 1 : 0);
            digits[n_digits-1-k]   = digits[k];
         end
         magnitude = '0;
         for (int k = 0; k < n_digits; k++) begin
            magnitude = magnitude * 10 + digits[k];
         end
      end
      w = magnitude[31:0];
      return $urandom_range(1) ? ~w + 32'd1 : w;
   endfunction

   function automatic word_type random_request_value();
      int unsigned sel;
      word_type    w;
      sel = $urandom_range(99);
      if (sel < 45) begin
         return random_palindrome();
      end else if (sel < 65) begin
         w = random_palindrome();
         if ($urandom_range(1)) begin
            return w ^ (32'd1 << $urandom_range(31));
         end
         return $urandom_range(1) ? w + 32'd1 : w - 32'd1;
      end
      return $urandom;
   endfunction

   task automatic offer(input word_type value, input bit passes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (passes) begin
         pending_palindromes.push_back(value);
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_palindromes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_palindromes.size() == 0) begin
               $error("palindrome_value: expected none, actual %0d",
                      $signed(rsp_palindrome_value));
               error_count++;
            end else begin
               expected_value = pending_palindromes.pop_front();
               if (rsp_palindrome_value !== expected_value) begin
                  $error("palindrome_value: expected %0d, actual %0d",
                         $signed(expected_value), $signed(rsp_palindrome_value));
                  error_count++;
               end
            end
         end
         if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      directed_case_type row;
      int                sent;
      word_type          value;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_cases[i];
         offer(row.value, row.typed ? row.passes : reads_same_reversed(row.value));
      end
      pause_until_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_ticket++;
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            value = random_request_value();
            offer(value, reads_same_reversed(value));
            sent++;
         end
         pause_until_drained();
      end

      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (pending_palindromes.size() != 0) begin
         $error("palindrome_value: %0d requests never produced a result",
                pending_palindromes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dpf_pkg.sv
src/decimal_palindrome_filter_top.sv
tb/sv/decimal_palindrome_filter_top_test.sv
